/* rtl/lms_pkg.sv */
// Shared constants for the longest monotone subsequence block.
`timescale 1ns / 1ps

package lms_pkg;

	localparam int MAX_ITEMS_DEF = 4096;

	localparam int SAMPLE_W  = 32;
	localparam int OUT_LEN_W = 13;
	localparam int REMOVE_W  = 13;

	// result tdata layout, lowest bit first
	localparam int RES_UP_LSB   = 0;
	localparam int RES_DN_LSB   = RES_UP_LSB + OUT_LEN_W;
	localparam int RES_SORT_BIT = RES_DN_LSB + OUT_LEN_W;
	localparam int RES_OVF_BIT  = RES_SORT_BIT + 1;
	localparam int RES_BITS     = RES_OVF_BIT + 1;
	localparam int RES_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [RES_TDATA_W-1:0] res_data_t;

endpackage

/* rtl/lms_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module lms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/longest_monotone_subsequence.sv */
// Top level: longest non-decreasing / non-increasing subsequence lengths of a stream.
//
// Input stream (s_axis_*): one signed 32-bit sample per transaction in tdata,
// tlast marks the final sample of a sequence. Output stream (m_axis_*): one
// result transaction per sequence, issued after its tlast sample, carrying
// both lengths, the sortability verdict and the overflow flag.
// cfg_wr_en / cfg_wr_data write the allowed-removal count; write it only
// while the block is idle.
// Each table lives in its own RAM and is searched by an upper-bound binary
// search, one RAM read per cycle, both tables in parallel; a sample's
// search ends once both tables have written its value as a new tail.
// A sample arriving once MAX_ITEMS are stored is dropped and only sets
// the overflow flag. After the last sample's search ends, the result is
// registered once the output register is free. s_axis_tready is high
// only between samples.
// A finished result waits in the output register while the next sequence
// is already accepted; a further result waits until that register frees.
// Reset clears lengths, counts and the output valid flag; RAM contents are
// not cleared, since only filled entries are ever read.
`timescale 1ns / 1ps

module longest_monotone_subsequence
	import lms_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample_value
	input  logic                   s_axis_tlast,   // is_last
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [RES_TDATA_W-1:0] m_axis_tdata,   // longest_up, longest_down,
	                                               // is_sortable, overflow, zero pad
	input  logic                   cfg_wr_en,
	input  logic [REMOVE_W-1:0]    cfg_wr_data     // allowed_removals
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int SW = ((CW > REMOVE_W) ? CW : REMOVE_W) + 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0]          state_q;
	sample_t             x_q;
	logic                last_q;
	logic [CW-1:0]       len_up_q, len_dn_q, count_q;
	logic                ovf_q;
	logic [REMOVE_W-1:0] allow_q;
	logic                out_valid_q;
	res_data_t           out_data_q;

	logic [CW-1:0] lo_up_q, hi_up_q, lo_dn_q, hi_dn_q;
	logic [AW-1:0] mid_up_q, mid_dn_q;
	logic          pend_up_q, pend_dn_q, done_up_q, done_dn_q;

	logic [SAMPLE_W-1:0] rdata_up, rdata_dn;
	logic                hit_up, hit_dn;
	logic [CW-1:0]       lo_up_n, hi_up_n, lo_dn_n, hi_dn_n;
	logic [CW:0]         sum_up, sum_dn;
	logic [AW-1:0]       mid_up_n, mid_dn_n;
	logic                go_up, go_dn, rd_up, rd_dn, wr_up, wr_dn;
	logic                s_acc, out_free;
	logic [CW-1:0]       best;
	logic [SW-1:0]       reach;
	res_data_t           res_word;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Search step: fold in the read issued last cycle, then pick the next probe.
	always_comb begin
		hit_up  = pend_up_q && ($signed(rdata_up) <= $signed(x_q));
		hit_dn  = pend_dn_q && ($signed(rdata_dn) >= $signed(x_q));
		lo_up_n = hit_up ? CW'(mid_up_q) + 1'b1 : lo_up_q;
		hi_up_n = (pend_up_q && !hit_up) ? CW'(mid_up_q) : hi_up_q;
		lo_dn_n = hit_dn ? CW'(mid_dn_q) + 1'b1 : lo_dn_q;
		hi_dn_n = (pend_dn_q && !hit_dn) ? CW'(mid_dn_q) : hi_dn_q;
		sum_up  = {1'b0, lo_up_n} + {1'b0, hi_up_n};
		sum_dn  = {1'b0, lo_dn_n} + {1'b0, hi_dn_n};
		mid_up_n = sum_up[AW:1];
		mid_dn_n = sum_dn[AW:1];
		go_up   = (state_q == ST_SEARCH) && !done_up_q;
		go_dn   = (state_q == ST_SEARCH) && !done_dn_q;
		rd_up   = go_up && (lo_up_n < hi_up_n);
		rd_dn   = go_dn && (lo_dn_n < hi_dn_n);
		wr_up   = go_up && !(lo_up_n < hi_up_n);
		wr_dn   = go_dn && !(lo_dn_n < hi_dn_n);
	end

	// Tables are written only at the end of a sample's search and read from the
	// next sample on, so a read never meets a write to the same entry.
	lms_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ITEMS)) u_tails_up (
		.clk   (clk),
		.we    (wr_up),
		.waddr (lo_up_n[AW-1:0]),
		.wdata (x_q),
		.raddr (mid_up_n),
		.rdata (rdata_up)
	);

	lms_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ITEMS)) u_tails_dn (
		.clk   (clk),
		.we    (wr_dn),
		.waddr (lo_dn_n[AW-1:0]),
		.wdata (x_q),
		.raddr (mid_dn_n),
		.rdata (rdata_dn)
	);

	always_comb begin
		best  = (len_up_q > len_dn_q) ? len_up_q : len_dn_q;
		reach = SW'(best) + SW'(allow_q);
		res_word = '0;
		res_word[RES_UP_LSB +: OUT_LEN_W] = OUT_LEN_W'(len_up_q);
		res_word[RES_DN_LSB +: OUT_LEN_W] = OUT_LEN_W'(len_dn_q);
		res_word[RES_SORT_BIT]            = (reach >= SW'(count_q));
		res_word[RES_OVF_BIT]             = ovf_q;
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			x_q    <= s_axis_tdata;
			last_q <= s_axis_tlast;
		end
		if (out_free && (state_q == ST_RESULT)) begin
			out_data_q <= res_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_up_q    <= '0;
			len_dn_q    <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			allow_q     <= '0;
			out_valid_q <= 1'b0;
			lo_up_q     <= '0;
			hi_up_q     <= '0;
			lo_dn_q     <= '0;
			hi_dn_q     <= '0;
			mid_up_q    <= '0;
			mid_dn_q    <= '0;
			pend_up_q   <= 1'b0;
			pend_dn_q   <= 1'b0;
			done_up_q   <= 1'b1;
			done_dn_q   <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				allow_q <= cfg_wr_data;
			end
			if ((state_q == ST_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (rd_up) begin
				lo_up_q   <= lo_up_n;
				hi_up_q   <= hi_up_n;
				mid_up_q  <= mid_up_n;
				pend_up_q <= 1'b1;
			end
			if (wr_up) begin
				pend_up_q <= 1'b0;
				done_up_q <= 1'b1;
				if (lo_up_n == len_up_q) begin
					len_up_q <= len_up_q + 1'b1;
				end
			end
			if (rd_dn) begin
				lo_dn_q   <= lo_dn_n;
				hi_dn_q   <= hi_dn_n;
				mid_dn_q  <= mid_dn_n;
				pend_dn_q <= 1'b1;
			end
			if (wr_dn) begin
				pend_dn_q <= 1'b0;
				done_dn_q <= 1'b1;
				if (lo_dn_n == len_dn_q) begin
					len_dn_q <= len_dn_q + 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (count_q < MAX_CNT) begin
							count_q   <= count_q + 1'b1;
							lo_up_q   <= '0;
							hi_up_q   <= len_up_q;
							lo_dn_q   <= '0;
							hi_dn_q   <= len_dn_q;
							pend_up_q <= 1'b0;
							pend_dn_q <= 1'b0;
							done_up_q <= 1'b0;
							done_dn_q <= 1'b0;
							state_q   <= ST_SEARCH;
						end else begin
							ovf_q   <= 1'b1;
							state_q <= s_axis_tlast ? ST_RESULT : ST_IDLE;
						end
					end
				end
				ST_SEARCH: begin
					if ((done_up_q || wr_up) && (done_dn_q || wr_dn)) begin
						state_q <= last_q ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						len_up_q    <= '0;
						len_dn_q    <= '0;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/lms_checker.sv */
// Port-level checker for the longest monotone subsequence block, with its bind.
`timescale 1ns / 1ps

module lms_checker
	import lms_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [SAMPLE_W-1:0]    s_axis_tdata,
	input logic                   s_axis_tlast,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [RES_TDATA_W-1:0] m_axis_tdata,
	input logic                   cfg_wr_en,
	input logic [REMOVE_W-1:0]    cfg_wr_data
);

	// count of sequences closed on the input side and not yet taken at the output
	logic [1:0] owed_q;
	logic       in_last_acc;

	assign in_last_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			case ({in_last_acc, m_axis_tvalid && m_axis_tready})
				2'b10: owed_q <= owed_q + 1'b1;
				2'b01: owed_q <= owed_q - 1'b1;
				default: owed_q <= owed_q;
			endcase
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a tlast sample closes the input in the cycle after it is taken
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input accepted right after a tlast sample");

	// a result is shown only once a tlast sample has been taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> owed_q != 2'd0)
		else $error("result without a closed sequence");

	// any sequence holds at least one stored sample, so neither length is zero
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (MAX_ITEMS < (1 << OUT_LEN_W)) |->
		(m_axis_tdata[RES_UP_LSB +: OUT_LEN_W] != '0) &&
		(m_axis_tdata[RES_DN_LSB +: OUT_LEN_W] != '0))
		else $error("zero length reported");

	logic unused_ok;
	assign unused_ok = ^{s_axis_tdata, cfg_wr_en, cfg_wr_data};

endmodule

bind longest_monotone_subsequence lms_checker #(.MAX_ITEMS(MAX_ITEMS)) u_lms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_wr_en     (cfg_wr_en),
	.cfg_wr_data   (cfg_wr_data)
);
